[rtl/core/ucdc_pkg.sv]
// ----------------------------------------------------------------------------
// ucdc_pkg: shared types and helpers for the epoch / civil date converter
// Word layouts, calendar constants and the small calendar tables.
// ----------------------------------------------------------------------------
package ucdc_pkg;

  // Day number offset carried down both paths: day number (since 1970-01-01)
  // plus this bias is never negative and is congruent to day + 4 mod 7.
  localparam int unsigned WK_W = 25;
  localparam logic [WK_W-1:0] WK_BIAS = 25'd865624;

  localparam logic [16:0] DAY_SEC    = 17'd86400;
  localparam logic [17:0] ERA_DAYS   = 18'd146097;
  localparam logic [19:0] EPOCH_DAY0 = 20'd719468;
  localparam logic [15:0] YEAR_MIN   = 16'd2000;
  localparam logic [15:0] YEAR_MAX   = 16'd2099;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } civil_t;

  typedef struct packed {
    logic [31:0]     epoch;
    civil_t          civ;
    logic [WK_W-1:0] wk;
  } conv_t;

  typedef struct packed {
    logic [31:0] epoch;
    civil_t      civ;
    logic [2:0]  weekday;
    logic        ok;
  } res_t;

  // First day of a March-based month within its year: (153 * mp + 2) / 5.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      4'd12:   d = 9'd367;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Days in a January-based month; zero for a month outside 1 to 12.
  function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
    logic [4:0] d;
    case (mo)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  // yoe / 100 for yoe below 400: (yoe * 41) >> 12 is exact there.
  function automatic logic [1:0] div100(input logic [8:0] yoe);
    logic [14:0] p;
    p = 15'(yoe) * 15'd41;
    return p[13:12];
  endfunction

  // Days before year-of-era yoe: 365 * yoe + yoe / 4 - yoe / 100.
  function automatic logic [17:0] yoe_days(input logic [8:0] yoe);
    return 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(div100(yoe));
  endfunction

endpackage

[rtl/core/ucdc_in_if.sv]
// ----------------------------------------------------------------------------
// ucdc_in_if: request channel of the converter
// Valid/ready handshake with the conversion kind and both input forms.
// ----------------------------------------------------------------------------
interface ucdc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] epoch_seconds_in;
  logic [15:0] year_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in;
  logic [4:0]  hour_in;
  logic [5:0]  minute_in;
  logic [5:0]  second_in;

  modport source (
    output valid, kind, epoch_seconds_in, year_in, month_in, day_in,
           hour_in, minute_in, second_in,
    input  ready
  );

  modport sink (
    input  valid, kind, epoch_seconds_in, year_in, month_in, day_in,
           hour_in, minute_in, second_in,
    output ready
  );
endinterface

[rtl/core/ucdc_out_if.sv]
// ----------------------------------------------------------------------------
// ucdc_out_if: result channel of the converter
// Valid/ready handshake with epoch count, civil fields, weekday and flag.
// ----------------------------------------------------------------------------
interface ucdc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds_out;
  logic [15:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;
  logic [2:0]  weekday;
  logic        valid_res;

  modport source (
    output valid, epoch_seconds_out, year_out, month_out, day_out, hour_out,
           minute_out, second_out, weekday, valid_res,
    input  ready
  );

  modport sink (
    input  valid, epoch_seconds_out, year_out, month_out, day_out, hour_out,
           minute_out, second_out, weekday, valid_res,
    output ready
  );
endinterface

[rtl/core/ucdc_civ2day.sv]
// ----------------------------------------------------------------------------
// ucdc_civ2day: civil date to epoch seconds, stages 1 to 7
// Era / day-of-era day count, then seconds modulo 2^32.
// ----------------------------------------------------------------------------
module ucdc_civ2day
  import ucdc_pkg::*;
(
  input  logic   clk,
  input  logic   adv,
  input  civil_t civ_in,
  output conv_t  res
);

  localparam logic [16:0] ERA_SHIFT = 17'd400;
  localparam logic [17:0] RCP400    = 18'd167773;  // ceil(2^26 / 400)
  localparam logic [WK_W-1:0] WK_OFS =
    WK_BIAS - WK_W'(32'(ERA_DAYS) + 32'(EPOCH_DAY0) + 32'd1);
  localparam logic [63:0] BIAS_SEC = 64'(WK_BIAS) * 64'(DAY_SEC);
  localparam logic [31:0] SEC_BIAS = 32'(~BIAS_SEC + 64'd1);

  // stage 1
  logic        mar;
  logic [3:0]  mp;
  logic [16:0] yb;
  logic [8:0]  doy1;
  logic [16:0] tod;

  always_comb begin
    mar  = (civ_in.month <= 4'd2);
    mp   = mar ? civ_in.month + 4'd9 : civ_in.month - 4'd3;
    yb   = {1'b0, civ_in.year} + ERA_SHIFT - {16'd0, mar};
    doy1 = month_start(mp) + {4'd0, civ_in.day};
    tod  = 17'(civ_in.hour) * 17'd3600 + 17'(civ_in.minute) * 17'd60
         + 17'(civ_in.second);
  end

  civil_t      s1_civ, s2_civ, s3_civ, s4_civ, s5_civ, s6_civ;
  logic [16:0] s1_yb, s2_yb;
  logic [8:0]  s1_doy, s2_doy, s3_doy;
  logic [16:0] s1_tod, s2_tod, s3_tod, s4_tod, s5_tod, s6_tod;
  logic [7:0]  s2_era, s3_era;
  logic [8:0]  s3_yoe;
  logic [17:0] s4_doe;
  logic [WK_W-1:0] s4_erad, s5_wk, s6_wk;
  logic [31:0] s6_prod;

  logic [34:0] era_prod;
  logic [41:0] sec_prod;

  assign era_prod = 35'(s1_yb) * 35'(RCP400);
  assign sec_prod = 42'(s5_wk) * 42'(DAY_SEC);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_civ  <= civ_in;
      s1_yb   <= yb;
      s1_doy  <= doy1;
      s1_tod  <= tod;

      s2_civ  <= s1_civ;
      s2_yb   <= s1_yb;
      s2_doy  <= s1_doy;
      s2_tod  <= s1_tod;
      s2_era  <= era_prod[33:26];

      s3_civ  <= s2_civ;
      s3_doy  <= s2_doy;
      s3_tod  <= s2_tod;
      s3_era  <= s2_era;
      s3_yoe  <= 9'(s2_yb - 17'(s2_era) * 17'd400);

      s4_civ  <= s3_civ;
      s4_tod  <= s3_tod;
      s4_doe  <= yoe_days(s3_yoe) + 18'(s3_doy);
      s4_erad <= WK_W'(s3_era) * WK_W'(ERA_DAYS);

      s5_civ  <= s4_civ;
      s5_tod  <= s4_tod;
      s5_wk   <= s4_erad + WK_W'(s4_doe) + WK_OFS;

      s6_civ  <= s5_civ;
      s6_tod  <= s5_tod;
      s6_wk   <= s5_wk;
      s6_prod <= sec_prod[31:0];

      res.civ   <= s6_civ;
      res.wk    <= s6_wk;
      res.epoch <= s6_prod + SEC_BIAS + 32'(s6_tod);
    end
  end

endmodule

[rtl/core/ucdc_day2civ.sv]
// ----------------------------------------------------------------------------
// ucdc_day2civ: epoch seconds to civil date, stages 1 to 7
// Day split, era and year of era, month and day, time of day.
// ----------------------------------------------------------------------------
module ucdc_day2civ
  import ucdc_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] epoch_in,
  output conv_t       res
);

  // Reciprocals, each exact over the operand range it sees.
  localparam logic [25:0] RCP675 = 26'd50903317;  // ceil(2^35 / 675)
  localparam logic [15:0] RCP365_24 = 16'd45965;  // ceil(2^24 / 365)
  localparam logic [17:0] RCP365_26 = 18'd183860; // ceil(2^26 / 365)
  localparam logic [12:0] RCP225 = 13'd4661;      // ceil(2^20 / 225)
  localparam logic [12:0] RCP15  = 13'd4370;      // ceil(2^16 / 15)
  localparam logic [12:0] RCP153 = 13'd6854;      // ceil(2^20 / 153)

  localparam logic [15:0] ERA5_DAY = 16'(32'(ERA_DAYS) * 32'd5 - 32'(EPOCH_DAY0));
  localparam logic [17:0] ERA4_OFS = 18'(32'(EPOCH_DAY0) - 32'(ERA_DAYS) * 32'd4);
  localparam logic [15:0] ERA4_YEAR = 16'd1600;
  localparam logic [15:0] ERA5_YEAR = 16'd2000;
  localparam logic [17:0] CENT1 = 18'd36524;
  localparam logic [17:0] CENT2 = 18'd73048;
  localparam logic [17:0] CENT3 = 18'd109572;
  localparam logic [17:0] CENT4 = 18'd146096;

  logic [50:0] day_prod;
  logic [31:0] day_sec;
  logic [25:0] hr_prod;
  logic [35:0] yoe_prod;
  logic [22:0] mi_prod;
  logic [23:0] mp_prod;
  logic [31:0] q1460_prod;
  logic [17:0] t3;
  logic [3:0]  mo7;

  logic [31:0] s1_ep, s2_ep, s3_ep, s4_ep, s5_ep, s6_ep;
  logic [15:0] s1_days;
  logic [WK_W-1:0] s2_wk, s3_wk, s4_wk, s5_wk, s6_wk;
  logic [16:0] s2_rem, s3_rem;
  logic [17:0] s2_doe, s3_doe, s4_doe;
  logic        s2_era5, s3_era5, s4_era5, s5_era5, s6_era5;
  logic [17:0] s3_t;
  logic [4:0]  s3_hr, s4_hr, s5_hr, s6_hr;
  logic [8:0]  s4_yoe, s5_yoe, s6_yoe;
  logic [11:0] s4_r2, s5_r2;
  logic [8:0]  s5_doy, s6_doy;
  logic [5:0]  s5_mi, s6_mi, s6_se;
  logic [3:0]  s6_mp;

  always_comb begin
    day_prod   = 51'(epoch_in[31:7]) * 51'(RCP675);
    day_sec    = 32'(s1_days) * 32'(DAY_SEC);
    q1460_prod = 32'(s2_doe[17:2]) * 32'(RCP365_24);
    t3 = s2_doe - 18'(q1460_prod[30:24])
       + 18'(s2_doe >= CENT1) + 18'(s2_doe >= CENT2) + 18'(s2_doe >= CENT3)
       + 18'(s2_doe >= CENT4) - 18'(s2_doe == CENT4);
    hr_prod  = 26'(s2_rem[16:4]) * 26'(RCP225);
    yoe_prod = 36'(s3_t) * 36'(RCP365_26);
    mi_prod  = 23'(s4_r2[11:2]) * 23'(RCP15);
    mp_prod  = 24'(11'(s5_doy) * 11'd5 + 11'd2) * 24'(RCP153);
    mo7      = (s6_mp < 4'd10) ? s6_mp + 4'd3 : s6_mp - 4'd9;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: whole days
      s1_ep   <= epoch_in;
      s1_days <= day_prod[50:35];

      // stage 2: seconds of day, era and day of era
      s2_ep   <= s1_ep;
      s2_wk   <= WK_W'(s1_days) + WK_BIAS;
      s2_rem  <= 17'(s1_ep - day_sec);
      s2_era5 <= (s1_days >= ERA5_DAY);
      s2_doe  <= (s1_days >= ERA5_DAY) ? 18'(s1_days - ERA5_DAY)
                                       : 18'(s1_days) + ERA4_OFS;

      // stage 3: leap-corrected day count, hour
      s3_ep   <= s2_ep;
      s3_wk   <= s2_wk;
      s3_rem  <= s2_rem;
      s3_era5 <= s2_era5;
      s3_doe  <= s2_doe;
      s3_t    <= t3;
      s3_hr   <= hr_prod[24:20];

      // stage 4: year of era, seconds of hour
      s4_ep   <= s3_ep;
      s4_wk   <= s3_wk;
      s4_era5 <= s3_era5;
      s4_doe  <= s3_doe;
      s4_hr   <= s3_hr;
      s4_yoe  <= yoe_prod[34:26];
      s4_r2   <= 12'(s3_rem - 17'(s3_hr) * 17'd3600);

      // stage 5: day of year, minute
      s5_ep   <= s4_ep;
      s5_wk   <= s4_wk;
      s5_era5 <= s4_era5;
      s5_hr   <= s4_hr;
      s5_yoe  <= s4_yoe;
      s5_r2   <= s4_r2;
      s5_doy  <= 9'(s4_doe - yoe_days(s4_yoe));
      s5_mi   <= mi_prod[21:16];

      // stage 6: March-based month, second
      s6_ep   <= s5_ep;
      s6_wk   <= s5_wk;
      s6_era5 <= s5_era5;
      s6_hr   <= s5_hr;
      s6_yoe  <= s5_yoe;
      s6_doy  <= s5_doy;
      s6_mi   <= s5_mi;
      s6_mp   <= mp_prod[23:20];
      s6_se   <= 6'(s5_r2 - 12'(s5_mi) * 12'd60);

      // stage 7: January-based month, day, year
      res.epoch      <= s6_ep;
      res.wk         <= s6_wk;
      res.civ.month  <= mo7;
      res.civ.day    <= 5'(s6_doy - month_start(s6_mp) + 9'd1);
      res.civ.year   <= 16'(s6_yoe) + (s6_era5 ? ERA5_YEAR : ERA4_YEAR)
                      + 16'(mo7 <= 4'd2);
      res.civ.hour   <= s6_hr;
      res.civ.minute <= s6_mi;
      res.civ.second <= s6_se;
    end
  end

endmodule

[rtl/core/ucdc_finish.sv]
// ----------------------------------------------------------------------------
// ucdc_finish: result select, range check and weekday, stages 8 and 9
// Picks the path for the kind, checks the date, reduces day number mod 7.
// ----------------------------------------------------------------------------
module ucdc_finish
  import ucdc_pkg::*;
(
  input  logic  clk,
  input  logic  adv,
  input  logic  kind,
  input  conv_t c2e,
  input  conv_t e2c,
  output res_t  res
);

  localparam logic [25:0] RCP7 = 26'd38347923;  // ceil(2^28 / 7)

  conv_t       sel;
  logic        leap;
  logic        ok;
  logic [50:0] q7_prod;

  logic [31:0]     s8_epoch;
  civil_t          s8_civ;
  logic [WK_W-1:0] s8_wk;
  logic [21:0]     s8_q7;
  logic            s8_ok;
  logic [WK_W-1:0] wk_rem;

  always_comb begin
    sel     = kind ? e2c : c2e;
    leap    = (sel.civ.year[1:0] == 2'd0);
    ok      = (sel.civ.year >= YEAR_MIN) && (sel.civ.year <= YEAR_MAX)
           && (sel.civ.month >= 4'd1) && (sel.civ.month <= 4'd12)
           && (sel.civ.day != 5'd0)
           && (sel.civ.day <= month_len(sel.civ.month, leap))
           && (sel.civ.hour <= 5'd23) && (sel.civ.minute <= 6'd59)
           && (sel.civ.second <= 6'd59);
    q7_prod = 51'(sel.wk) * 51'(RCP7);
    wk_rem  = s8_wk - WK_W'(s8_q7) * WK_W'(7);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_epoch <= sel.epoch;
      s8_civ   <= sel.civ;
      s8_wk    <= sel.wk;
      s8_q7    <= q7_prod[49:28];
      s8_ok    <= ok;

      res.epoch   <= s8_epoch;
      res.civ     <= s8_civ;
      res.weekday <= wk_rem[2:0] + 3'd1;
      res.ok      <= s8_ok;
    end
  end

endmodule

[rtl/core/unix_time_civil_date_converter_core.sv]
// ----------------------------------------------------------------------------
// unix_time_civil_date_converter_core: epoch seconds / civil date converter
//
// Request channel req carries one word per conversion: kind 0 turns the civil
// date and time fields into seconds since 1970 (wrapped to 32 bits), kind 1
// turns epoch_seconds_in into a civil date and time. The other direction's
// input fields are ignored. Each request produces exactly one word on rsp
// carrying both forms, the day of week (1 Sunday to 7 Saturday) and
// valid_res, set for years 2000 to 2099 with every field in range.
// The pipe has nine register stages, and a new word is taken in every cycle
// while rsp is not stalled. The depth is set by the reciprocal multipliers,
// which are spread over the stages together with the adds and compares.
// A stall on rsp freezes all stages at once, so req.ready drops in the same
// cycle and no word is lost or repeated; bubbles move along with the data.
// Reset clears the stage valid bits only; the data and kind registers are not reset.
// ----------------------------------------------------------------------------
module unix_time_civil_date_converter_core
  import ucdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  ucdc_in_if.sink   req,
  ucdc_out_if.source rsp
);

  localparam int unsigned STAGES      = 9;
  localparam int unsigned PATH_STAGES = 7;

  // One valid bit per stage; the last one is the output register.
  logic [STAGES-1:0]      vld;
  logic [PATH_STAGES-1:0] kind_pipe;
  logic                   adv;

  civil_t civ_in;
  conv_t  c2e;
  conv_t  e2c;
  res_t   res;

  // Advance the whole pipe unless a finished word is held by the receiver.
  assign adv       = !vld[STAGES-1] || rsp.ready;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], req.valid};
    end
  end

  // Kind travels alongside the two paths to pick the result at stage 8.
  always_ff @(posedge clk) begin
    if (adv) begin
      kind_pipe <= {kind_pipe[PATH_STAGES-2:0], req.kind};
    end
  end

  assign civ_in.year   = req.year_in;
  assign civ_in.month  = req.month_in;
  assign civ_in.day    = req.day_in;
  assign civ_in.hour   = req.hour_in;
  assign civ_in.minute = req.minute_in;
  assign civ_in.second = req.second_in;

  // Civil date to epoch: stages 1 to 7.
  ucdc_civ2day u_civ2day (
    .clk    (clk),
    .adv    (adv),
    .civ_in (civ_in),
    .res    (c2e)
  );

  // Epoch to civil date: stages 1 to 7.
  ucdc_day2civ u_day2civ (
    .clk      (clk),
    .adv      (adv),
    .epoch_in (req.epoch_seconds_in),
    .res      (e2c)
  );

  // Select, range check and weekday: stages 8 and 9.
  ucdc_finish u_finish (
    .clk  (clk),
    .adv  (adv),
    .kind (kind_pipe[PATH_STAGES-1]),
    .c2e  (c2e),
    .e2c  (e2c),
    .res  (res)
  );

  assign rsp.valid             = vld[STAGES-1];
  assign rsp.epoch_seconds_out = res.epoch;
  assign rsp.year_out          = res.civ.year;
  assign rsp.month_out         = res.civ.month;
  assign rsp.day_out           = res.civ.day;
  assign rsp.hour_out          = res.civ.hour;
  assign rsp.minute_out        = res.civ.minute;
  assign rsp.second_out        = res.civ.second;
  assign rsp.weekday           = res.weekday;
  assign rsp.valid_res         = res.ok;

endmodule
